/* hw/rtl/hmr_pkg.sv */
package hmr_pkg;

  // Fixed payload widths of the two channels.
  localparam int BAR_W  = 16;
  localparam int AREA_W = 26;

  // Largest area that the result field can carry; larger areas saturate here.
  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  // Commands from the controller to the datapath; at most one is raised at a time.
  typedef struct packed {
    logic latch;     // capture the incoming bar beat
    logic set_ovf;   // bar arrived with no room left
    logic pop;       // score and remove the top entry
    logic load_top;  // refill the top entry from the stack memory
    logic push;      // push the held bar
    logic emit;      // write the result register and clear the histogram state
  } hmr_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic stack_empty;
    logic top_taller;
    logic bar_full;
    logic last;
    logic out_free;
  } hmr_status_t;

endpackage

/* hw/rtl/hmr_if.sv */
interface hmr_bar_if;
  import hmr_pkg::*;

  logic             valid;
  logic             ready;
  logic [BAR_W-1:0] bar_height;
  logic             last_bar;

  modport source (output valid, bar_height, last_bar, input ready);
  modport sink   (input valid, bar_height, last_bar, output ready);
endinterface

interface hmr_res_if;
  import hmr_pkg::*;

  logic              valid;
  logic              ready;
  logic [AREA_W-1:0] max_area;
  logic              overflow;

  modport source (output valid, max_area, overflow, input ready);
  modport sink   (input valid, max_area, overflow, output ready);
endinterface

/* hw/rtl/hmr_ram.sv */
module hmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/hmr_ctrl.sv */
module hmr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                bar_valid_i,
  output logic                bar_ready_o,
  input  hmr_pkg::hmr_status_t status_i,
  output hmr_pkg::hmr_cmd_t    cmd_o
);
  import hmr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_FLOAD = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    bar_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        bar_ready_o = 1'b1;
        if (bar_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_CMP;
        end
      end
      S_CMP: begin
        if (status_i.bar_full) begin
          cmd_o.set_ovf = 1'b1;
          state_d       = status_i.last ? S_FLUSH : S_IDLE;
        end else if (!status_i.stack_empty && status_i.top_taller) begin
          cmd_o.pop = 1'b1;
          state_d   = S_LOAD;
        end else begin
          cmd_o.push = 1'b1;
          state_d    = status_i.last ? S_FLUSH : S_IDLE;
        end
      end
      S_LOAD: begin
        cmd_o.load_top = 1'b1;
        state_d        = S_CMP;
      end
      S_FLUSH: begin
        if (!status_i.stack_empty) begin
          cmd_o.pop = 1'b1;
          state_d   = S_FLOAD;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_FLOAD: begin
        cmd_o.load_top = 1'b1;
        state_d        = S_FLUSH;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/hmr_dp.sv */
module hmr_dp #(
  parameter int MAX_BARS    = 1024,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hmr_pkg::hmr_cmd_t           cmd_i,
  output hmr_pkg::hmr_status_t        status_o,
  input  logic [hmr_pkg::BAR_W-1:0]   bar_height_i,
  input  logic                        last_bar_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [hmr_pkg::AREA_W-1:0]  max_area_o,
  output logic                        overflow_o
);
  import hmr_pkg::*;

  localparam int HW  = (HEIGHT_BITS < BAR_W) ? HEIGHT_BITS : BAR_W;
  localparam int PW  = $clog2(MAX_BARS);
  localparam int CW  = $clog2(MAX_BARS + 1);
  localparam int EW  = HW + PW;
  localparam int PRW = HW + CW;
  localparam int PXW = (PRW > AREA_W) ? PRW : AREA_W;

  logic [HW-1:0]     h_q;
  logic              last_q;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     bars_q, bars_d;
  logic [HW-1:0]     top_h_q;
  logic [PW-1:0]     top_left_q;
  logic [PW-1:0]     run_left_q;
  logic [PRW-1:0]    prod_q;
  logic              prod_vld_q;
  logic [AREA_W-1:0] best_q, best_d;
  logic              ovf_q, ovf_d;
  logic              res_valid_q;
  logic [AREA_W-1:0] res_area_q;
  logic              res_ovf_q;

  logic [CW-1:0]     cnt_m1, cnt_m2, span;
  logic [PRW-1:0]    prod_d;
  logic [PXW-1:0]    prod_x;
  logic [AREA_W-1:0] sat_area;
  logic [EW-1:0]     ram_rdata;

  // Stack entries below the top one; each holds its height and left edge.
  assign cnt_m1 = count_q - CW'(1);
  assign cnt_m2 = count_q - CW'(2);

  hmr_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BARS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push && (count_q != '0)),
    .waddr_i (cnt_m1[PW-1:0]),
    .wdata_i ({top_h_q, top_left_q}),
    .re_i    (cmd_i.pop),
    .raddr_i (cnt_m2[PW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Score of the top entry: height times the span from its left edge to the bar count.
  assign span   = bars_q - CW'(top_left_q);
  assign prod_d = PRW'(top_h_q) * PRW'(span);

  // Saturate the registered product to the result width.
  assign prod_x   = PXW'(prod_q);
  assign sat_area = (prod_x > PXW'(AREA_MAX)) ? AREA_MAX : prod_x[AREA_W-1:0];

  // Next values of the control counters and flags.
  always_comb begin
    count_d = count_q;
    bars_d  = bars_q;
    best_d  = best_q;
    ovf_d   = ovf_q;
    if (prod_vld_q && (sat_area > best_q)) begin
      best_d = sat_area;
    end
    if (cmd_i.set_ovf) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.pop) begin
      count_d = cnt_m1;
    end
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
      bars_d  = bars_q + CW'(1);
    end
    if (cmd_i.emit) begin
      count_d = '0;
      bars_d  = '0;
      best_d  = '0;
      ovf_d   = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      bars_q      <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      prod_vld_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      bars_q     <= bars_d;
      best_q     <= best_d;
      ovf_q      <= ovf_d;
      prod_vld_q <= cmd_i.pop;
      if (cmd_i.emit) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: held bar, top entry, running left edge, product, result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      h_q        <= bar_height_i[HW-1:0];
      last_q     <= last_bar_i;
      run_left_q <= bars_q[PW-1:0];
    end
    if (cmd_i.pop) begin
      prod_q     <= prod_d;
      run_left_q <= top_left_q;
    end
    if (cmd_i.load_top && (count_q != '0)) begin
      top_h_q    <= ram_rdata[EW-1:PW];
      top_left_q <= ram_rdata[PW-1:0];
    end
    if (cmd_i.push) begin
      top_h_q    <= h_q;
      top_left_q <= run_left_q;
    end
    if (cmd_i.emit) begin
      res_area_q <= best_q;
      res_ovf_q  <= ovf_q;
    end
  end

  // Status back to the controller.
  assign status_o.stack_empty = (count_q == '0);
  assign status_o.top_taller  = (top_h_q > h_q);
  assign status_o.bar_full    = (bars_q == CW'(MAX_BARS));
  assign status_o.last        = last_q;
  assign status_o.out_free    = !res_valid_q || res_ready_i;

  assign res_valid_o = res_valid_q;
  assign max_area_o  = res_area_q;
  assign overflow_o  = res_ovf_q;

endmodule

/* hw/rtl/histogram_max_rectangle.sv */
// Channel   Dir   Payload                      Beat meaning
// bar_i     in    bar_height[16], last_bar     one histogram bar, left to right
// res_o     out   max_area[26], overflow       one result per histogram
//
// Each bar is accepted, then compared and pushed, with a pop and a refill of the
// top entry for every entry it pops from the stack; the pop loop is bound by the
// registered read of the stack memory that refills the top entry.
// The last bar adds a pop and a refill per entry left on the stack, then a write of
// the result register. Reset clears all counters at once; the stack memory
// needs no clearing. A waiting result stalls the block only when the next result is ready.
module histogram_max_rectangle #(
  parameter int MAX_BARS    = 1024,
  parameter int HEIGHT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hmr_bar_if.sink    bar_i,
  hmr_res_if.source  res_o
);
  import hmr_pkg::*;

  hmr_cmd_t    cmd;
  hmr_status_t status;

  // Sequencer.
  hmr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bar_valid_i (bar_i.valid),
    .bar_ready_o (bar_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Stack, scoring and result register.
  hmr_dp #(
    .MAX_BARS    (MAX_BARS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .bar_height_i (bar_i.bar_height),
    .last_bar_i   (bar_i.last_bar),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .max_area_o   (res_o.max_area),
    .overflow_o   (res_o.overflow)
  );

  // A pop never targets an empty stack.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !status.stack_empty)
    else $error("pop issued on an empty stack");

  // Pop and push never share a cycle.
  a_pop_push_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.pop && cmd.push))
    else $error("pop and push in the same cycle");

  // The block does not accept a bar in the cycle after it accepts one.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bar_i.valid && bar_i.ready) |=> !bar_i.ready)
    else $error("bar accepted while the previous one is in work");

  // A result beat appears only after the result register was written.
  a_res_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(cmd.emit))
    else $error("result valid without a write of the result register");

endmodule

/* tb/tb.sv */
module tb;
  import hmr_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 6;
  localparam int STACK_DEPTH  = 1024;
  localparam int RANDOM_BARS  = 300;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_GAP      = 13;

  typedef longint unsigned u64_t;

  localparam u64_t AREA_CAP = u64_t'(AREA_MAX);

  // Height profiles for generated histograms.
  typedef enum int {
    SHAPE_WIDE,
    SHAPE_LOW,
    SHAPE_RISE,
    SHAPE_FALL,
    SHAPE_TALL
  } shape_e;

  typedef struct {
    logic [BAR_W-1:0] height;
    logic             last;
    int unsigned      gap;
    bit               hold_mark;
  } bar_beat_t;

  typedef struct {
    logic [AREA_W-1:0] area;
    logic              ovf;
  } hist_result_t;

  typedef struct {
    int unsigned      pos;
    logic [BAR_W-1:0] height;
  } stack_entry_t;

  logic clk;
  logic rst_n;

  hmr_bar_if bar_if ();
  hmr_res_if res_if ();

  histogram_max_rectangle dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .bar_i  (bar_if),
    .res_o  (res_if)
  );

  // Bars waiting to be driven and areas waiting to come out.
  bar_beat_t    bar_queue[$];
  hist_result_t area_expect[$];

  // Mirror of the block's histogram state.
  stack_entry_t bar_stack[$];
  int unsigned  bars_in_hist = 0;
  u64_t         best_area    = 0;
  bit           ovf_seen     = 1'b0;

  // Handshake flags sampled at the rising edge, read at the falling edge.
  logic bar_fire = 1'b0;
  logic res_fire = 1'b0;

  int unsigned bars_total     = 0;
  int unsigned bars_taken     = 0;
  int unsigned mismatch_count = 0;

  // Driver and receiver bookkeeping.
  bar_beat_t   cur_beat;
  bit          beat_loaded = 1'b0;
  int unsigned gap_left    = 0;
  logic        hold_req    = 1'b0;
  bit          hold_taken  = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned rx_beats    = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Pop the top entry and score the rectangle it spans up to end_pos.
  task automatic score_top(input int unsigned end_pos);
    stack_entry_t top;
    u64_t         left;
    u64_t         tall;
    u64_t         span_area;
    top = bar_stack.pop_back();
    left = (bar_stack.size() == 0) ? 0 : u64_t'(bar_stack[$].pos) + 1;
    tall = top.height;
    span_area = tall * (u64_t'(end_pos) - left);
    if (span_area > AREA_CAP) span_area = AREA_CAP;
    if (span_area > best_area) best_area = span_area;
  endtask

  // Advance the mirrored state by one accepted bar beat.
  task automatic predict_bar(input logic [BAR_W-1:0] h, input logic last);
    hist_result_t res;
    stack_entry_t ent;
    if (bars_in_hist < STACK_DEPTH) begin
      while (bar_stack.size() > 0 && bar_stack[$].height > h) score_top(bars_in_hist);
      if (bar_stack.size() < STACK_DEPTH) begin
        ent.pos    = bars_in_hist;
        ent.height = h;
        bar_stack.insert(bar_stack.size(), ent);
      end
      bars_in_hist++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (last) begin
      while (bar_stack.size() > 0) score_top(bars_in_hist);
      res.area = best_area[AREA_W-1:0];
      res.ovf  = ovf_seen;
      area_expect.insert(area_expect.size(), res);
      bars_in_hist = 0;
      best_area    = 0;
      ovf_seen     = 1'b0;
    end
  endtask

  task automatic queue_bar(input logic [BAR_W-1:0] h, input logic last, input int unsigned gap,
                           input bit mark = 1'b0);
    bar_beat_t b;
    b.height    = h;
    b.last      = last;
    b.gap       = gap;
    b.hold_mark = mark;
    bar_queue.insert(bar_queue.size(), b);
    bars_total++;
  endtask

  // Queue one histogram of the given length and profile.
  task automatic queue_histogram(input int unsigned len, input shape_e shape, input bit no_gaps);
    logic [BAR_W-1:0] h;
    h = (shape == SHAPE_FALL) ? 16'hFFFF - BAR_W'($urandom_range(0, 4000))
                              : BAR_W'($urandom_range(0, 4000));
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_WIDE: h = BAR_W'($urandom());
        SHAPE_LOW:  h = BAR_W'($urandom_range(0, 7));
        SHAPE_RISE: h = h + BAR_W'($urandom_range(0, 300));
        SHAPE_FALL: h = h - BAR_W'($urandom_range(0, 300));
        default:    h = 16'hFFFF - BAR_W'($urandom_range(0, 3));
      endcase
      queue_bar(h, i == len - 1, no_gaps ? 0 : $urandom_range(0, MAX_GAP));
    end
  endtask

  // Bar driver: holds each beat until it is taken, then waits out the next gap.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(bar_if.valid && !bar_fire)) begin
        if (!beat_loaded && bar_queue.size() > 0) begin
          cur_beat    = bar_queue.pop_front();
          beat_loaded = 1'b1;
          gap_left    = cur_beat.gap;
        end
        if (beat_loaded && gap_left == 0) begin
          bar_if.valid      <= 1'b1;
          bar_if.bar_height <= cur_beat.height;
          bar_if.last_bar   <= cur_beat.last;
          if (cur_beat.hold_mark) hold_req <= 1'b1;
          beat_loaded = 1'b0;
        end else begin
          bar_if.valid <= 1'b0;
          if (beat_loaded) gap_left--;
        end
      end
    end
  end

  // Result receiver: random stalls after each beat, quiet stretches, one long hold.
  always @(negedge clk) begin
    if (rst_n) begin
      if (res_fire) begin
        rx_beats++;
        stall_left = ((rx_beats / 10) % 3 == 0) ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on every bar beat, check every result beat.
  always @(posedge clk) begin
    hist_result_t want;
    bar_fire <= rst_n && bar_if.valid && bar_if.ready;
    res_fire <= rst_n && res_if.valid && res_if.ready;
    if (rst_n && bar_if.valid && bar_if.ready) begin
      predict_bar(bar_if.bar_height, bar_if.last_bar);
      bars_taken++;
    end
    if (rst_n && res_if.valid && res_if.ready) begin
      if (area_expect.size() == 0) begin
        $error("unexpected result beat: max_area %0d overflow %0d",
               res_if.max_area, res_if.overflow);
        mismatch_count++;
      end else begin
        want = area_expect.pop_front();
        if (res_if.max_area !== want.area) begin
          $error("max_area expected %0d got %0d", want.area, res_if.max_area);
          mismatch_count++;
        end
        if (res_if.overflow !== want.ovf) begin
          $error("overflow expected %0d got %0d", want.ovf, res_if.overflow);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned rand_bars;
    int unsigned len;
    bit          burst_done;
    bit          no_gaps;
    logic [BAR_W-1:0] dir_bars[$];

    bar_if.valid      = 1'b0;
    bar_if.bar_height = '0;
    bar_if.last_bar   = 1'b0;
    res_if.ready      = 1'b0;
    rst_n             = 1'b0;

    // Directed: extremes, equal heights, pops in both directions.
    queue_bar(16'h0000, 1'b1, 0);
    queue_bar(16'hFFFF, 1'b1, 3);
    dir_bars = '{16'd3, 16'd3, 16'd3};
    foreach (dir_bars[i]) queue_bar(dir_bars[i], i == dir_bars.size() - 1, 0);
    dir_bars = '{16'd2, 16'd1, 16'd5, 16'd6, 16'd2, 16'd3};
    foreach (dir_bars[i]) queue_bar(dir_bars[i], i == dir_bars.size() - 1, i);
    dir_bars = '{16'd1, 16'd2, 16'd3, 16'd4};
    foreach (dir_bars[i]) queue_bar(dir_bars[i], i == dir_bars.size() - 1, 0);
    dir_bars = '{16'd4, 16'd3, 16'd2, 16'd1};
    foreach (dir_bars[i]) queue_bar(dir_bars[i], i == dir_bars.size() - 1, 1);
    dir_bars = '{16'h0000, 16'hFFFF, 16'h0000};
    foreach (dir_bars[i]) queue_bar(dir_bars[i], i == dir_bars.size() - 1, 0);
    queue_bar(16'hAAAA, 1'b0, 0);
    queue_bar(16'h5555, 1'b1, 2);

    // A full stack of the tallest bars gives the largest possible area; one more
    // bar runs past the stack and sets the overflow flag.
    for (int i = 0; i <= STACK_DEPTH; i++) queue_bar(16'hFFFF, i == STACK_DEPTH, 0);

    // Random histograms with one stall burst.
    rand_bars  = 0;
    burst_done = 1'b0;
    while (rand_bars < RANDOM_BARS) begin
      if (!burst_done && rand_bars >= 100) begin
        // Back-to-back single-bar histograms while the receiver holds off.
        burst_done = 1'b1;
        for (int k = 0; k < 24; k++) queue_bar(BAR_W'($urandom()), 1'b1, 0, k == 0);
        rand_bars += 24;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        no_gaps = ($urandom_range(0, 3) == 0);
        queue_histogram(len, shape_e'($urandom_range(SHAPE_WIDE, SHAPE_TALL)), no_gaps);
        rand_bars += len;
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (bars_taken == bars_total);
    wait (area_expect.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (area_expect.size() != 0) begin
      $error("%0d expected results never arrived", area_expect.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(CLK_PERIOD * 1000000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
